// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/cbl_pkg.sv =====
// ---------------------------------------------------------------------------
// cbl_pkg
// Types, constants, microcode table and arithmetic helpers of the cascaded
// biquad low-pass filter.
// ---------------------------------------------------------------------------
package cbl_pkg;

   // Structure
   localparam int MAX_SECTIONS         = 2;
   localparam int NUM_SECTIONS_DEFAULT = 2;

   // Field widths
   localparam int SAMPLE_W = 24;
   localparam int HIST_W   = 32;
   localparam int COEF_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int CREG_W   = 64;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = HIST_W + MUL_B_W;
   localparam int ACC_W    = 52;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF0 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF1 = 2'd2;

   // Sequencer step addresses
   typedef logic [3:0] step_type;
   localparam step_type STEP_WAIT     = 4'd0;
   localparam step_type STEP_GAIN_MUL = 4'd1;
   localparam step_type STEP_GAIN_SAT = 4'd2;
   localparam step_type STEP_W_MUL1   = 4'd3;
   localparam step_type STEP_W_MUL2   = 4'd4;
   localparam step_type STEP_W_ACC2   = 4'd5;
   localparam step_type STEP_W_SAT    = 4'd6;
   localparam step_type STEP_Y_MUL1   = 4'd7;
   localparam step_type STEP_Y_MUL2   = 4'd8;
   localparam step_type STEP_Y_ACC2   = 4'd9;
   localparam step_type STEP_Y_SAT    = 4'd10;
   localparam step_type STEP_OUT      = 4'd11;

   // Control word fields
   typedef enum logic [1:0] {MA_SAMPLE, MA_H1, MA_H2} mul_a_type;
   typedef enum logic [2:0] {MB_GAIN, MB_C0, MB_C1, MB_C2, MB_C3} mul_b_type;
   typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD_X, ACC_LOAD_W, ACC_SUB, ACC_ADD} acc_op_type;
   typedef enum logic [2:0] {WR_NONE, WR_X_GAIN, WR_W, WR_X_HIST, WR_OUT} wr_type;
   typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_LOOP, JMP_HOLD_OUT} jmp_type;

   typedef struct packed {
      logic       mul_en;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      wr_type     wr;
      jmp_type    jmp;
      step_type   target;
   } ucode_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   // Configuration registers
   typedef struct packed {
      logic [GAIN_W-1:0]                   gain;
      logic [MAX_SECTIONS-1:0][CREG_W-1:0] coef;
   } cfg_type;

   // Microcode program, one control word per step
   function automatic ucode_type ucode_at(input step_type pc);
      ucode_type u;
      u.mul_en = 1'b0;
      u.mul_a  = MA_SAMPLE;
      u.mul_b  = MB_GAIN;
      u.acc_op = ACC_HOLD;
      u.wr     = WR_NONE;
      u.jmp    = JMP_NEXT;
      u.target = STEP_WAIT;
      unique case (pc)
         STEP_WAIT: begin
            u.jmp = JMP_WAIT_IN;
         end
         STEP_GAIN_MUL: begin
            u.mul_en = 1'b1;
         end
         STEP_GAIN_SAT: begin
            u.wr = WR_X_GAIN;
         end
         STEP_W_MUL1: begin
            u.mul_en = 1'b1; u.mul_a = MA_H1; u.mul_b = MB_C0; u.acc_op = ACC_LOAD_X;
         end
         STEP_W_MUL2: begin
            u.mul_en = 1'b1; u.mul_a = MA_H2; u.mul_b = MB_C1; u.acc_op = ACC_SUB;
         end
         STEP_W_ACC2: begin
            u.acc_op = ACC_SUB;
         end
         STEP_W_SAT: begin
            u.wr = WR_W;
         end
         STEP_Y_MUL1: begin
            u.mul_en = 1'b1; u.mul_a = MA_H1; u.mul_b = MB_C2; u.acc_op = ACC_LOAD_W;
         end
         STEP_Y_MUL2: begin
            u.mul_en = 1'b1; u.mul_a = MA_H2; u.mul_b = MB_C3; u.acc_op = ACC_ADD;
         end
         STEP_Y_ACC2: begin
            u.acc_op = ACC_ADD;
         end
         STEP_Y_SAT: begin
            u.wr = WR_X_HIST; u.jmp = JMP_LOOP; u.target = STEP_W_MUL1;
         end
         STEP_OUT: begin
            u.wr = WR_OUT; u.jmp = JMP_HOLD_OUT; u.target = STEP_WAIT;
         end
         default: begin
            u.jmp = JMP_HOLD_OUT; u.target = STEP_WAIT;
         end
      endcase
      return u;
   endfunction

   // Saturate a wide signed value to Q1.31
   function automatic logic [HIST_W-1:0] sat_q31(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(64'sd2147483647);
      lo = ACC_W'(-64'sd2147483648);
      if (v > hi) return hi[HIST_W-1:0];
      if (v < lo) return lo[HIST_W-1:0];
      return v[HIST_W-1:0];
   endfunction

endpackage

// ===== rtl/cascaded_biquad_lowpass_top.sv =====
// ---------------------------------------------------------------------------
// cascaded_biquad_lowpass_top
// Gain stage plus cascaded direct form II biquad sections, microcoded.
// ---------------------------------------------------------------------------
// Each accepted sample is scaled by the Q4.12 gain and run through
// NUM_SECTIONS second-order sections on one shared 32x17 multiplier under a
// microcoded step counter. From acceptance to the result register a sample
// passes two steps for the gain product, eight per section (four products,
// two accumulate-only steps and two saturations) and one to load the output.
// A new sample is taken only once the step is back in the wait state, so the
// previous sample must first be loaded into the output register. The next
// sample is taken while a result still waits in the output register; the
// sequencer only holds at the output step if that register is still full
// and not being read. History is cleared by reset; configuration writes
// never stall.
// ---------------------------------------------------------------------------
module cascaded_biquad_lowpass_top #(
   parameter int NUM_SECTIONS = cbl_pkg::NUM_SECTIONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cbl_pkg::SAMPLE_W-1:0]    req_tdata,   // [23:0] sample_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cbl_pkg::SAMPLE_W-1:0]    rsp_tdata,   // [23:0] sample_out
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cbl_pkg::CREG_W-1:0]      csr_data
);
   import cbl_pkg::*;

   localparam int SecW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

   cfg_type         cfg_ff;
   ucode_type       ctrl;
   dp_status_type   status;
   logic            in_take;
   logic [SecW-1:0] sec;

   // Configuration registers, always ready to be written
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain <= GAIN_RESET;
         cfg_ff.coef <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GAIN:  cfg_ff.gain    <= csr_data[GAIN_W-1:0];
            CSR_COEF0: cfg_ff.coef[0] <= csr_data;
            CSR_COEF1: cfg_ff.coef[1] <= csr_data;
            default:   ;
         endcase
      end
   end

   cbl_sequencer #(.NUM_SECTIONS(NUM_SECTIONS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl),
      .in_take    (in_take),
      .sec        (sec)
   );

   cbl_datapath #(.NUM_SECTIONS(NUM_SECTIONS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sec        (sec),
      .in_take    (in_take),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .status     (status)
   );

endmodule

// ===== rtl/cbl_sequencer.sv =====
// ---------------------------------------------------------------------------
// cbl_sequencer
// Step counter, section counter and microcode table; issues one control
// word per cycle to the datapath.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbl_sequencer #(
   parameter  int NUM_SECTIONS = cbl_pkg::NUM_SECTIONS_DEFAULT,
   localparam int SecW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cbl_pkg::dp_status_type status,
   output cbl_pkg::ucode_type    ctrl,
   output logic                  in_take,
   output logic [SecW-1:0]       sec
);
   import cbl_pkg::*;

   step_type        pc_ff, pc_in;
   logic [SecW-1:0] sec_ff, sec_in;

   // Control word of the current step
   assign ctrl       = ucode_at(pc_ff);
   assign req_tready = (ctrl.jmp == JMP_WAIT_IN);
   assign in_take    = req_tvalid && req_tready;
   assign sec        = sec_ff;

   // Next step and section
   always_comb begin
      pc_in  = pc_ff;
      sec_in = sec_ff;
      unique case (ctrl.jmp)
         JMP_NEXT: begin
            pc_in = pc_ff + 1'b1;
         end
         JMP_WAIT_IN: begin
            if (in_take) pc_in = pc_ff + 1'b1;
         end
         JMP_LOOP: begin
            if (sec_ff == SecW'(NUM_SECTIONS - 1)) begin
               sec_in = '0;
               pc_in  = pc_ff + 1'b1;
            end else begin
               sec_in = sec_ff + 1'b1;
               pc_in  = ctrl.target;
            end
         end
         JMP_HOLD_OUT: begin
            if (!status.out_busy) pc_in = ctrl.target;
         end
         default: begin
            pc_in = STEP_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_WAIT;
         sec_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         sec_ff <= sec_in;
      end
   end

   // Checks
   `ASSERT_CLK(a_sec_range, clock, reset, sec_ff <= SecW'(NUM_SECTIONS - 1), "section out of range")
   `ASSERT_CLK(a_take_starts, clock, reset, in_take |=> pc_ff == STEP_GAIN_MUL, "sample not started")
   `ASSERT_CLK(a_wait_sec0, clock, reset, (pc_ff == STEP_WAIT) |-> (sec_ff == '0), "section left set")

endmodule

// ===== rtl/cbl_datapath.sv =====
// ---------------------------------------------------------------------------
// cbl_datapath
// Shared multiplier, accumulator, saturation, section history and the
// output register, all driven by the sequencer's control word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbl_datapath #(
   parameter  int NUM_SECTIONS = cbl_pkg::NUM_SECTIONS_DEFAULT,
   localparam int SecW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbl_pkg::ucode_type            ctrl,
   input  logic [SecW-1:0]               sec,
   input  logic                          in_take,
   input  cbl_pkg::cfg_type              cfg,
   input  logic [cbl_pkg::SAMPLE_W-1:0]  req_tdata,   // [23:0] sample_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cbl_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [23:0] sample_out
   output cbl_pkg::dp_status_type        status
);
   import cbl_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [HIST_W-1:0]   x_ff, w_ff;
   logic signed [HIST_W-1:0]   h1_ff [NUM_SECTIONS];
   logic signed [HIST_W-1:0]   h2_ff [NUM_SECTIONS];
   logic [SAMPLE_W-1:0]        out_ff;
   logic                       out_vld_ff, out_vld_in;

   logic signed [HIST_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic [CREG_W-1:0]          creg;
   logic signed [ACC_W-1:0]    prod_ext, x_ext, w_ext;
   logic                       out_load;

   assign creg     = cfg.coef[sec];
   assign prod_ext = ACC_W'(prod_ff);
   assign x_ext    = {{(ACC_W - HIST_W - 13){x_ff[HIST_W-1]}}, x_ff, 13'd0};
   assign w_ext    = {{(ACC_W - HIST_W - 13){w_ff[HIST_W-1]}}, w_ff, 13'd0};

   // Multiplier operand select
   always_comb begin
      unique case (ctrl.mul_a)
         MA_SAMPLE: mul_a = HIST_W'(sample_ff);
         MA_H1:     mul_a = h1_ff[sec];
         MA_H2:     mul_a = h2_ff[sec];
         default:   mul_a = '0;
      endcase
      unique case (ctrl.mul_b)
         MB_GAIN: mul_b = {1'b0, cfg.gain};
         MB_C0:   mul_b = MUL_B_W'(signed'(creg[15:0]));
         MB_C1:   mul_b = MUL_B_W'(signed'(creg[31:16]));
         MB_C2:   mul_b = MUL_B_W'(signed'(creg[47:32]));
         MB_C3:   mul_b = MUL_B_W'(signed'(creg[63:48]));
         default: mul_b = '0;
      endcase
   end

   // Accumulator
   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:   acc_in = acc_ff;
         ACC_LOAD_X: acc_in = x_ext;
         ACC_LOAD_W: acc_in = w_ext;
         ACC_SUB:    acc_in = acc_ff - prod_ext;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         default:    acc_in = acc_ff;
      endcase
   end

   // Output register handshake
   assign status.out_busy = out_vld_ff && !rsp_tready;
   assign out_load        = (ctrl.wr == WR_OUT) && !status.out_busy;
   always_comb begin
      out_vld_in = out_vld_ff && !rsp_tready;
      if (out_load) out_vld_in = 1'b1;
   end
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) sample_ff <= req_tdata;
      if (ctrl.mul_en) prod_ff <= PROD_W'(mul_a * mul_b);
      acc_ff <= acc_in;
      unique case (ctrl.wr)
         WR_X_GAIN: x_ff <= sat_q31(prod_ext >>> 4);
         WR_W:      w_ff <= sat_q31(acc_ff >>> 13);
         WR_X_HIST: x_ff <= sat_q31(acc_ff >>> 13);
         WR_OUT:    if (out_load) out_ff <= x_ff[HIST_W-1:HIST_W-SAMPLE_W];
         WR_NONE:   ;
         default:   ;
      endcase
   end

   // Section history, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SECTIONS; i++) begin
            h1_ff[i] <= '0;
            h2_ff[i] <= '0;
         end
      end else if (ctrl.wr == WR_X_HIST) begin
         h2_ff[sec] <= h1_ff[sec];
         h1_ff[sec] <= w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= out_vld_in;
   end

   // Checks
   `ASSERT_CLK(a_out_load_valid, clock, reset, out_load |=> rsp_tvalid, "result not presented")
   `ASSERT_CLK(a_hist_hold, clock, reset, (ctrl.wr != WR_X_HIST) |=> $stable(h1_ff[0]), "history moved")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result dropped")

endmodule
